// ===== hw/rtl/credential_acl_table_assert.svh =====
// Assertion macros used by the checker file of the access-control table.
`ifndef CREDENTIAL_ACL_TABLE_ASSERT_SVH
`define CREDENTIAL_ACL_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define CACL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("credential_acl_table: assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define CACL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("credential_acl_table: assertion failed");

`endif

// ===== hw/rtl/cacl_pkg.sv =====
`timescale 1ns / 1ps

package cacl_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int CRED_COUNT    = 256;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int REQ_W   = 2;
    localparam int CRED_W  = 8;
    localparam int AGENT_W = 32;
    localparam int MASK_W  = 32;
    localparam int TIME_W  = 64;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = MASK_W + TIME_W;

    localparam int S_DATA_W = 208;
    localparam int M_DATA_W = 8;

    localparam logic [REQ_W-1:0] REQ_CHECK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GRANT  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REVOKE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_sts;

endpackage

// ===== hw/rtl/credential_acl_table.sv =====
`timescale 1ns / 1ps

// Access-control table of up to 32 entries, each binding a credential and an agent key to an
// operation mask and an expiry time. A request item is a check, a grant, a revoke or a no-op;
// each gives exactly one result item with an allowed flag and a status. All stored keys are
// compared in parallel in the cycle after an item is taken, and the matching entry's mask and
// expiry are read from a RAM, so an item goes through a lookup step, then an evaluate and
// write-back step. A new item is taken in the cycle its predecessor's result is written to the
// output register, so items do not overlap; a result left waiting holds the block in its
// evaluate step.
module credential_acl_table import cacl_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // cred_index[7:0], cred_known[8], agent_key[40:9], op_mask[72:41],
    // expiry_time[136:73], now_time[200:137], zero padding above.
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // req_type[1:0].
    input  logic [REQ_W-1:0]    i_s_tuser,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // allowed[0], status[2:1], zero padding above.
    output logic [M_DATA_W-1:0] o_m_tdata
);

    t_cmd              cmd;
    t_sts              sts;
    logic              allowed;
    logic [STAT_W-1:0] status;

    cacl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cacl_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_s_tuser),
        .i_cred_index  (i_s_tdata[7:0]),
        .i_cred_known  (i_s_tdata[8]),
        .i_agent_key   (i_s_tdata[40:9]),
        .i_op_mask     (i_s_tdata[72:41]),
        .i_expiry_time (i_s_tdata[136:73]),
        .i_now_time    (i_s_tdata[200:137]),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_allowed     (allowed),
        .o_status      (status)
    );

    assign o_m_tdata = {{(M_DATA_W - 1 - STAT_W){1'b0}}, status, allowed};

endmodule

// ===== hw/rtl/cacl_ram.sv =====
`timescale 1ns / 1ps

module cacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                         i_clk,
    input  logic                                         i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                             i_wr_data,
    input  logic                                         i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                             o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/cacl_ctrl.sv =====
`timescale 1ns / 1ps

module cacl_ctrl import cacl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  logic i_m_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       commit;
    logic       ready;
    logic       capture;

    assign commit  = (r_state == S_EVAL) && (!i_sts.out_full || i_m_tready);
    assign ready   = i_rst_n && ((r_state == S_IDLE) || commit);
    assign capture = i_s_tvalid && ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (capture) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (capture) begin
                    n_state = S_LOOK;
                end else if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready     = ready;
    assign o_cmd.capture  = capture;
    assign o_cmd.lookup   = (r_state == S_LOOK);
    assign o_cmd.commit   = commit;

endmodule

// ===== hw/rtl/cacl_dp.sv =====
`timescale 1ns / 1ps

module cacl_dp import cacl_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [CRED_W-1:0]   i_cred_index,
    input  logic                i_cred_known,
    input  logic [AGENT_W-1:0]  i_agent_key,
    input  logic [MASK_W-1:0]   i_op_mask,
    input  logic [TIME_W-1:0]   i_expiry_time,
    input  logic [TIME_W-1:0]   i_now_time,
    input  logic                i_m_tready,
    output logic                o_m_tvalid,
    output logic                o_allowed,
    output logic [STAT_W-1:0]   o_status
);

    // Request held while it is looked up and evaluated.
    logic [REQ_W-1:0]   r_req;
    logic [CRED_W-1:0]  r_cred;
    logic               r_known;
    logic [AGENT_W-1:0] r_agent;
    logic [MASK_W-1:0]  r_mask;
    logic [TIME_W-1:0]  r_exp;
    logic [TIME_W-1:0]  r_now;

    // Key store, compared in parallel.
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [CRED_W-1:0]        r_key_cred  [TABLE_ENTRIES];
    logic [AGENT_W-1:0]       r_key_agent [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] match;
    logic                     hit;
    logic [IDX_W-1:0]         hit_idx;
    logic                     free;
    logic [IDX_W-1:0]         free_idx;

    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_free;
    logic [IDX_W-1:0] r_free_idx;

    logic [ENTRY_W-1:0] rd_data;
    logic [MASK_W-1:0]  ent_ops;
    logic [TIME_W-1:0]  ent_exp;

    logic               known_ok;
    logic               expired;
    logic               res_allowed;
    logic [STAT_W-1:0]  res_status;
    logic               wr_key;
    logic               clr_key;
    logic [IDX_W-1:0]   wr_idx;

    logic               r_out_valid;
    logic               r_allowed;
    logic [STAT_W-1:0]  r_status;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req   <= i_req_type;
            r_cred  <= i_cred_index;
            r_known <= i_cred_known;
            r_agent <= i_agent_key;
            r_mask  <= i_op_mask;
            r_exp   <= i_expiry_time;
            r_now   <= i_now_time;
        end
    end

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_key_cred[i] == r_cred) && (r_key_agent[i] == r_agent);
        end
    end

    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        free     = 1'b0;
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                free     = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_hit      <= hit;
            r_hit_idx  <= hit_idx;
            r_free     <= free;
            r_free_idx <= free_idx;
        end
    end

    assign ent_ops = rd_data[ENTRY_W-1:TIME_W];
    assign ent_exp = rd_data[TIME_W-1:0];

    assign known_ok = r_known && (32'(r_cred) < 32'(CRED_COUNT));
    assign expired  = (ent_exp != '0) && (r_now > ent_exp);

    always_comb begin
        res_allowed = 1'b0;
        res_status  = ST_OK;
        wr_key      = 1'b0;
        clr_key     = 1'b0;
        wr_idx      = r_hit ? r_hit_idx : r_free_idx;
        if (r_req == REQ_NONE) begin
            res_status = ST_OK;
        end else if (!known_ok) begin
            res_status = ST_UNKNOWN;
        end else begin
            case (r_req)
                REQ_CHECK: begin
                    if (r_hit && !expired && ((ent_ops & r_mask) != '0)) begin
                        res_allowed = 1'b1;
                        res_status  = ST_OK;
                    end else begin
                        res_status = ST_NOMATCH;
                    end
                end
                REQ_GRANT: begin
                    if (r_hit || r_free) begin
                        wr_key     = 1'b1;
                        res_status = ST_OK;
                    end else begin
                        res_status = ST_FULL;
                    end
                end
                REQ_REVOKE: begin
                    if (r_hit) begin
                        clr_key    = 1'b1;
                        res_status = ST_OK;
                    end else begin
                        res_status = ST_NOMATCH;
                    end
                end
                default: begin
                    res_status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.commit) begin
            if (wr_key) begin
                r_valid[wr_idx] <= 1'b1;
            end else if (clr_key) begin
                r_valid[r_hit_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_key) begin
            r_key_cred[wr_idx]  <= r_cred;
            r_key_agent[wr_idx] <= r_agent;
        end
    end

    cacl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.commit && wr_key),
        .i_wr_addr (wr_idx),
        .i_wr_data ({r_mask, r_exp}),
        .i_rd_en   (i_cmd.lookup),
        .i_rd_addr (hit_idx),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_allowed <= res_allowed;
            r_status  <= res_status;
        end
    end

    assign o_sts.out_full = r_out_valid;
    assign o_m_tvalid     = r_out_valid;
    assign o_allowed      = r_allowed;
    assign o_status       = r_status;

endmodule

// ===== hw/rtl/cacl_checker.sv =====
`timescale 1ns / 1ps
`include "credential_acl_table_assert.svh"

module cacl_checker import cacl_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tvalid,
    input logic                o_s_tready,
    input logic [S_DATA_W-1:0] i_s_tdata,
    input logic [REQ_W-1:0]    i_s_tuser,
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [M_DATA_W-1:0] o_m_tdata
);

    logic out_stall;
    logic in_take;
    logic granted;

    assign out_stall = o_m_tvalid && !i_m_tready;
    assign in_take   = i_s_tvalid && o_s_tready;
    assign granted   = o_m_tvalid && o_m_tdata[0];

    `CACL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_m_tvalid && $stable(o_m_tdata))
    `CACL_ASSERT_NOW(a_allow_ok, i_clk, i_rst_n, granted, o_m_tdata[2:1] == ST_OK)
    `CACL_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, in_take, !o_s_tready)
    `CACL_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[M_DATA_W-1:3] == '0)

endmodule

bind credential_acl_table cacl_checker u_cacl_checker (.*);
